@@ rtl/scfp_pkg.sv @@
// settings command frame parser: shared types and constants
// holds byte roles, verdicts, parse phases, command codes and register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scfp_pkg;

  // command bytes
  localparam logic [7:0] CMD_NAME    = 8'h01;
  localparam logic [7:0] CMD_WIFI    = 8'h02;
  localparam logic [7:0] CMD_HISTORY = 8'h03;
  localparam logic [7:0] CMD_OTA     = 8'h04;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SSID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PW   = 2'd2;

  // limit reset values
  localparam logic [7:0] RST_MAX_NAME = 8'd20;
  localparam logic [7:0] RST_MAX_SSID = 8'd32;
  localparam logic [7:0] RST_MAX_PW   = 8'd64;

  typedef enum logic [2:0] {
    PH_CMD      = 3'd0,
    PH_NAME     = 3'd1,
    PH_SSID_LEN = 3'd2,
    PH_SSID     = 3'd3,
    PH_PW_LEN   = 3'd4,
    PH_PW       = 3'd5,
    PH_IGNORE   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_CMD      = 3'd0,
    ROLE_NAME     = 3'd1,
    ROLE_SSID_LEN = 3'd2,
    ROLE_SSID     = 3'd3,
    ROLE_PW_LEN   = 3'd4,
    ROLE_PW       = 3'd5,
    ROLE_IGNORED  = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    V_PENDING  = 3'd0,
    V_NAME     = 3'd1,
    V_WIFI     = 3'd2,
    V_HISTORY  = 3'd3,
    V_OTA      = 3'd4,
    V_BAD_NAME = 3'd5,
    V_BAD_WIFI = 3'd6,
    V_UNKNOWN  = 3'd7
  } verdict_t;

  typedef struct packed {
    logic [7:0] max_name;
    logic [7:0] max_ssid;
    logic [7:0] max_pw;
  } limits_t;

  typedef struct packed {
    role_t      role;
    logic [7:0] value;
    logic [7:0] offset;
    logic       frame_end;
    verdict_t   verdict;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/scfp_core.sv @@
// settings command frame parser: per-frame parse state and per-byte result logic
// depends on scfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module scfp_core
  import scfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] frame_byte,
  input  wire logic       last_byte,
  input  wire limits_t    limits,
  output result_t         result
);

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int OW = (CW > 8) ? CW : 8;

  phase_t        phase_r, phase_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    ssid_len_r, ssid_len_nxt;
  logic [7:0]    pw_len_r, pw_len_nxt;
  logic [7:0]    cd_r, cd_nxt;
  logic          bad_r, bad_nxt;

  logic          sat;
  logic [OW-1:0] idx_m1;
  logic [OW-1:0] name_n;
  logic [7:0]    cd_dec;

  always_comb begin
    sat          = (count_r >= CW'(MAX_FRAME_BYTES));
    count_nxt    = sat ? count_r : count_r + CW'(1);
    bad_nxt      = bad_r | sat;
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    ssid_len_nxt = ssid_len_r;
    pw_len_nxt   = pw_len_r;
    cd_nxt       = cd_r;
    idx_m1       = OW'(count_r) - OW'(1);
    cd_dec       = cd_r - 8'd1;

    result.role      = ROLE_IGNORED;
    result.value     = frame_byte;
    result.offset    = 8'd0;
    result.frame_end = last_byte;
    result.verdict   = V_PENDING;

    case (phase_r)
      PH_CMD: begin
        result.role = ROLE_CMD;
        cmd_nxt     = frame_byte;
        if (frame_byte == CMD_NAME) begin
          phase_nxt = PH_NAME;
        end else if (frame_byte == CMD_WIFI) begin
          phase_nxt = PH_SSID_LEN;
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end
      PH_NAME: begin
        result.role   = ROLE_NAME;
        // offset saturates for overlong names
        result.offset = (idx_m1 > OW'(255)) ? 8'hFF : idx_m1[7:0];
      end
      PH_SSID_LEN: begin
        result.role  = ROLE_SSID_LEN;
        ssid_len_nxt = frame_byte;
        if (frame_byte > limits.max_ssid) begin
          bad_nxt   = 1'b1;
          phase_nxt = PH_IGNORE;
        end else if (frame_byte == 8'd0) begin
          phase_nxt = PH_PW_LEN;
        end else begin
          cd_nxt    = frame_byte;
          phase_nxt = PH_SSID;
        end
      end
      PH_SSID: begin
        result.role   = ROLE_SSID;
        result.offset = ssid_len_r - cd_r;
        cd_nxt        = cd_dec;
        if (cd_dec == 8'd0) begin
          phase_nxt = PH_PW_LEN;
        end
      end
      PH_PW_LEN: begin
        result.role = ROLE_PW_LEN;
        pw_len_nxt  = frame_byte;
        if (frame_byte > limits.max_pw) begin
          bad_nxt   = 1'b1;
          phase_nxt = PH_IGNORE;
        end else if (frame_byte == 8'd0) begin
          phase_nxt = PH_IGNORE;
        end else begin
          cd_nxt    = frame_byte;
          phase_nxt = PH_PW;
        end
      end
      PH_PW: begin
        result.role   = ROLE_PW;
        result.offset = pw_len_r - cd_r;
        cd_nxt        = cd_dec;
        if (cd_dec == 8'd0) begin
          phase_nxt = PH_IGNORE;
        end
      end
      default: begin
        result.role = ROLE_IGNORED;
        phase_nxt   = PH_IGNORE;
      end
    endcase

    // verdict from the state as it stands after this byte
    name_n = OW'(count_nxt) - OW'(1);
    if (last_byte) begin
      case (cmd_nxt)
        CMD_NAME: begin
          if (bad_nxt || name_n == '0 || name_n > OW'(limits.max_name)) begin
            result.verdict = V_BAD_NAME;
          end else begin
            result.verdict = V_NAME;
          end
        end
        CMD_WIFI: begin
          if (bad_nxt || phase_nxt != PH_IGNORE) begin
            result.verdict = V_BAD_WIFI;
          end else begin
            result.verdict = V_WIFI;
          end
        end
        CMD_HISTORY: result.verdict = V_HISTORY;
        CMD_OTA:     result.verdict = V_OTA;
        default:     result.verdict = V_UNKNOWN;
      endcase
      // ready for a new frame
      phase_nxt    = PH_CMD;
      cmd_nxt      = 8'd0;
      count_nxt    = '0;
      ssid_len_nxt = 8'd0;
      pw_len_nxt   = 8'd0;
      cd_nxt       = 8'd0;
      bad_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CMD;
      cmd_r      <= 8'd0;
      count_r    <= '0;
      ssid_len_r <= 8'd0;
      pw_len_r   <= 8'd0;
      cd_r       <= 8'd0;
      bad_r      <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      count_r    <= count_nxt;
      ssid_len_r <= ssid_len_nxt;
      pw_len_r   <= pw_len_nxt;
      cd_r       <= cd_nxt;
      bad_r      <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scfp_out_buf.sv @@
// settings command frame parser: two-entry result buffer (output register plus skid)
// depends on scfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module scfp_out_buf
  import scfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_push,
  output logic         out_valid,
  output result_t      out_data,
  input  wire logic    out_ready
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    pop            = main_valid_r && out_ready;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (!main_valid_r) begin
      main_valid_nxt = push;
      main_nxt       = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/settings_command_frame_parser_top.sv @@
// settings command frame parser: top level with limit registers
// depends on scfp_pkg, scfp_core and scfp_out_buf
//
// usage:
// - in channel (in_valid/in_ready) carries one frame byte per item plus a
//   last-byte mark; byte 0 of each frame is the command
// - out channel (out_valid/out_ready) returns exactly one item per input
//   item: the byte's role, the byte itself, its offset in its field, and
//   on the last byte the frame verdict
// - cfg channel writes the name, ssid and password length limits; it is
//   always ready, unknown indexes are dropped
// - throughput is one item per cycle while in_ready is high, set by the
//   single parse stage whose state (phase, counts, countdown) updates
//   once per accepted byte
// - results sit in an output register backed by a skid entry, so one more
//   item is taken while a result waits; in_ready drops only when both
//   entries are full and recovers the cycle after the receiver takes one
// - reset (synchronous, active low) restores the default limits, empties
//   the result buffer and leaves the parser waiting for a command byte
// - the frame byte counter saturates at MAX_FRAME_BYTES; a byte past that
//   marks name and wifi frames bad
`timescale 1ns / 1ps
`default_nettype none

module settings_command_frame_parser_top
  import scfp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_frame_byte,
  input  wire logic                 in_last_byte,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_byte_role,
  output logic [7:0]                out_byte_value,
  output logic [7:0]                out_field_offset,
  output logic                      out_frame_end,
  output logic [2:0]                out_verdict,
  // limit register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  limits_t limits_r;
  result_t core_result;
  result_t buf_result;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // limit registers, a new limit applies from the next byte on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_name <= RST_MAX_NAME;
      limits_r.max_ssid <= RST_MAX_SSID;
      limits_r.max_pw   <= RST_MAX_PW;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_NAME: limits_r.max_name <= cfg_data;
        REG_MAX_SSID: limits_r.max_ssid <= cfg_data;
        REG_MAX_PW:   limits_r.max_pw   <= cfg_data;
        default: ;
      endcase
    end
  end

  // parse stage: role, offset and verdict for the accepted byte
  scfp_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .frame_byte(in_frame_byte),
    .last_byte (in_last_byte),
    .limits    (limits_r),
    .result    (core_result)
  );

  // result register with skid entry
  scfp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .push_data(core_result),
    .can_push (in_ready),
    .out_valid(out_valid),
    .out_data (buf_result),
    .out_ready(out_ready)
  );

  assign out_byte_role    = buf_result.role;
  assign out_byte_value   = buf_result.value;
  assign out_field_offset = buf_result.offset;
  assign out_frame_end    = buf_result.frame_end;
  assign out_verdict      = buf_result.verdict;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for settings_command_frame_parser_top: byte roles, field offsets and verdicts
// predicts every result from its own copy of the parser state and limits
// depends on scfp_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;
  import scfp_pkg::*;

  localparam int FRAME_CAP   = 256;   // frame byte counter saturation
  localparam int ITEM_TARGET = 1950;  // input items before the stimulus stops
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // index with no register

  typedef logic [7:0] byte_q_t[$];

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // every block input starts at a known value
  logic                 in_valid      = 1'b0;
  logic [7:0]           in_frame_byte = 8'h00;
  logic                 in_last_byte  = 1'b0;
  logic                 out_ready     = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_MAX_NAME;
  logic [7:0]           cfg_data      = 8'h00;

  logic       in_ready;
  logic       out_valid;
  logic [2:0] out_byte_role;
  logic [7:0] out_byte_value;
  logic [7:0] out_field_offset;
  logic       out_frame_end;
  logic [2:0] out_verdict;
  logic       cfg_ready;

  settings_command_frame_parser_top #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_byte    (in_frame_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_role    (out_byte_role),
    .out_byte_value   (out_byte_value),
    .out_field_offset (out_field_offset),
    .out_frame_end    (out_frame_end),
    .out_verdict      (out_verdict),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run bookkeeping
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned gap_pct    = 0;   // chance of an input idle burst before an item
  int unsigned stall_pct  = 0;   // chance of a result stall burst per cycle
  int unsigned stall_left = 0;

  // expected results, oldest first
  result_t parsed_byte_q[$];

  // parser state mirror, reset values
  logic [7:0]  lim_name     = RST_MAX_NAME;
  logic [7:0]  lim_ssid     = RST_MAX_SSID;
  logic [7:0]  lim_pw       = RST_MAX_PW;
  phase_t      frm_phase    = PH_CMD;
  logic [7:0]  frm_cmd      = 8'h00;
  int unsigned frm_count    = 0;
  logic [7:0]  frm_ssid_len = 8'h00;
  logic [7:0]  frm_pw_len   = 8'h00;
  logic [7:0]  frm_left     = 8'h00;
  logic        frm_bad      = 1'b0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_count < 200)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic verdict_t frame_verdict();
    case (frm_cmd)
      CMD_NAME: begin
        // name byte count excludes the command byte
        if (frm_bad || frm_count - 1 == 0 || frm_count - 1 > lim_name) return V_BAD_NAME;
        return V_NAME;
      end
      CMD_WIFI: begin
        // only a frame that got past the password is complete
        if (frm_bad || frm_phase != PH_IGNORE) return V_BAD_WIFI;
        return V_WIFI;
      end
      CMD_HISTORY: return V_HISTORY;
      CMD_OTA:     return V_OTA;
      default:     return V_UNKNOWN;
    endcase
  endfunction

  // advances the mirror by one byte and gives the result the block must return
  function automatic result_t parse_byte(input logic [7:0] value, input logic is_last);
    result_t     res;
    int unsigned pos;
    pos           = frm_count;
    res.role      = ROLE_IGNORED;
    res.value     = value;
    res.offset    = 8'h00;
    res.frame_end = is_last;
    res.verdict   = V_PENDING;

    // saturating byte counter, overflow poisons name and wifi frames
    if (frm_count >= FRAME_CAP) frm_bad = 1'b1;
    else frm_count++;

    case (frm_phase)
      PH_CMD: begin
        res.role = ROLE_CMD;
        frm_cmd  = value;
        if (value == CMD_NAME) frm_phase = PH_NAME;
        else if (value == CMD_WIFI) frm_phase = PH_SSID_LEN;
        else frm_phase = PH_IGNORE;
      end
      PH_NAME: begin
        res.role   = ROLE_NAME;
        res.offset = (pos - 1 > 255) ? 8'hff : 8'(pos - 1);
      end
      PH_SSID_LEN: begin
        res.role     = ROLE_SSID_LEN;
        frm_ssid_len = value;
        if (value > lim_ssid) begin
          frm_bad   = 1'b1;
          frm_phase = PH_IGNORE;
        end else if (value == 8'h00) begin
          frm_phase = PH_PW_LEN;
        end else begin
          frm_left  = value;
          frm_phase = PH_SSID;
        end
      end
      PH_SSID: begin
        res.role   = ROLE_SSID;
        res.offset = frm_ssid_len - frm_left;
        frm_left   = frm_left - 8'd1;
        if (frm_left == 8'h00) frm_phase = PH_PW_LEN;
      end
      PH_PW_LEN: begin
        res.role   = ROLE_PW_LEN;
        frm_pw_len = value;
        if (value > lim_pw) begin
          frm_bad   = 1'b1;
          frm_phase = PH_IGNORE;
        end else if (value == 8'h00) begin
          frm_phase = PH_IGNORE;
        end else begin
          frm_left  = value;
          frm_phase = PH_PW;
        end
      end
      PH_PW: begin
        res.role   = ROLE_PW;
        res.offset = frm_pw_len - frm_left;
        frm_left   = frm_left - 8'd1;
        if (frm_left == 8'h00) frm_phase = PH_IGNORE;
      end
      default: begin
        res.role  = ROLE_IGNORED;
        frm_phase = PH_IGNORE;
      end
    endcase

    if (is_last) begin
      res.verdict  = frame_verdict();
      frm_phase    = PH_CMD;
      frm_cmd      = 8'h00;
      frm_count    = 0;
      frm_ssid_len = 8'h00;
      frm_pw_len   = 8'h00;
      frm_left     = 8'h00;
      frm_bad      = 1'b0;
    end
    return res;
  endfunction

  // checks each result against the oldest expectation, then records
  // limit writes and predicts newly accepted items
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (parsed_byte_q.size() == 0) begin
          report_mismatch("result with nothing expected, value", out_byte_value, 8'h00);
        end else begin
          want = parsed_byte_q.pop_front();
          if (out_byte_role !== want.role)
            report_mismatch("byte_role", 8'(out_byte_role), 8'(want.role));
          if (out_byte_value !== want.value)
            report_mismatch("byte_value", out_byte_value, want.value);
          if (out_field_offset !== want.offset)
            report_mismatch("field_offset", out_field_offset, want.offset);
          if (out_frame_end !== want.frame_end)
            report_mismatch("frame_end", 8'(out_frame_end), 8'(want.frame_end));
          if (out_verdict !== want.verdict)
            report_mismatch("verdict", 8'(out_verdict), 8'(want.verdict));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_NAME: lim_name = cfg_data;
          REG_MAX_SSID: lim_ssid = cfg_data;
          REG_MAX_PW:   lim_pw   = cfg_data;
          default: ;  // no register there, write dropped
        endcase
      end
      if (in_valid && in_ready)
        parsed_byte_q.push_back(parse_byte(in_frame_byte, in_last_byte));
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid stays up between back-to-back items; in this task it only drops for a gap
  task automatic send_item(input logic [7:0] value, input logic is_last);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= value;
    in_last_byte  <= is_last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // sends the bytes in order, marking the final one only when closing the frame
  task automatic send_frame(input byte_q_t bytes, input logic close_frame);
    foreach (bytes[i])
      send_item(bytes[i], close_frame && (i == bytes.size() - 1));
  endtask

  // stops input and waits until every expected result has been checked
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (parsed_byte_q.size() != 0);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // limits lean to the extremes and to small values that frames can reach
  function automatic logic [7:0] random_limit();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3:       return 8'($urandom_range(2, 12));
      default: return rand_byte();
    endcase
  endfunction

  // field length: mostly short, sometimes right at the limit or one past it
  function automatic int unsigned field_len(input int unsigned limit);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, (limit < 8) ? limit : 8);
    if (pick == 7 && limit <= 40) return limit;
    if (pick == 8 && limit < 40) return limit + 1;
    return $urandom_range(0, 8);
  endfunction

  task automatic send_random_frame();
    byte_q_t     fr;
    int unsigned kind;
    int unsigned n;
    logic [7:0]  cmd;
    kind = $urandom_range(0, 19);
    if (kind < 7) begin
      fr.push_back(CMD_NAME);
      n = field_len(lim_name);
      repeat (n) fr.push_back(rand_byte());
    end else if (kind < 15) begin
      fr.push_back(CMD_WIFI);
      n = field_len(lim_ssid);
      fr.push_back(8'(n));
      repeat (n) fr.push_back(rand_byte());
      n = field_len(lim_pw);
      fr.push_back(8'(n));
      repeat (n) fr.push_back(rand_byte());
      repeat ($urandom_range(0, 3)) fr.push_back(rand_byte());
      // cut short now and then
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, fr.size());
        while (fr.size() > n) fr.delete(fr.size() - 1);
      end
    end else if (kind < 17) begin
      fr.push_back(kind == 15 ? CMD_HISTORY : CMD_OTA);
      repeat ($urandom_range(0, 3)) fr.push_back(rand_byte());
    end else if (kind < 19) begin
      do cmd = rand_byte();
      while (cmd == CMD_NAME || cmd == CMD_WIFI || cmd == CMD_HISTORY || cmd == CMD_OTA);
      fr.push_back(cmd);
      repeat ($urandom_range(0, 3)) fr.push_back(rand_byte());
    end else begin
      // noise: any command byte and random content
      repeat ($urandom_range(1, 7)) fr.push_back(rand_byte());
    end
    send_frame(fr, 1'b1);
  endtask

  // every command, empty fields, trailing bytes, short and oversized wifi
  task automatic test_directed_frames();
    gap_pct   = 20;
    stall_pct = 20;
    send_frame('{CMD_NAME, 8'h41, 8'h42}, 1'b1);
    send_frame('{CMD_NAME}, 1'b1);
    send_frame('{CMD_WIFI, 8'h02, 8'h61, 8'h62, 8'h01, 8'h70, 8'hff}, 1'b1);
    send_frame('{CMD_WIFI, 8'h00, 8'h00}, 1'b1);
    send_frame('{CMD_HISTORY}, 1'b1);
    send_frame('{CMD_OTA}, 1'b1);
    send_frame('{8'hff}, 1'b1);
    send_frame('{8'h00, 8'h80}, 1'b1);
    send_frame('{CMD_WIFI, 8'h03, 8'h78}, 1'b1);
    send_frame('{CMD_WIFI, 8'hff, 8'h00}, 1'b1);
    send_frame('{CMD_WIFI, 8'h00, 8'hff}, 1'b1);
  endtask

  // tightest and loosest limits, zero name limit, write to an empty index
  task automatic test_limit_extremes();
    write_limit(REG_MAX_NAME, 8'd1);
    write_limit(REG_MAX_SSID, 8'd0);
    write_limit(REG_MAX_PW, 8'd0);
    send_frame('{CMD_NAME, 8'haa}, 1'b1);
    send_frame('{CMD_NAME, 8'haa, 8'hbb}, 1'b1);
    send_frame('{CMD_WIFI, 8'h00, 8'h00, 8'h55}, 1'b1);
    send_frame('{CMD_WIFI, 8'h01, 8'h33}, 1'b1);
    send_frame('{CMD_WIFI, 8'h00, 8'h01, 8'h33}, 1'b1);

    write_limit(REG_MAX_NAME, 8'd255);
    write_limit(REG_MAX_SSID, 8'd255);
    write_limit(REG_MAX_PW, 8'd255);
    repeat (6) send_random_frame();

    write_limit(REG_MAX_NAME, 8'd0);
    send_frame('{CMD_NAME, 8'h7f}, 1'b1);

    // the empty index must leave the name limit alone
    write_limit(REG_MAX_NAME, RST_MAX_NAME);
    write_limit(REG_UNUSED, 8'd0);
    send_frame('{CMD_NAME, 8'h11, 8'h22, 8'h33}, 1'b1);
  endtask

  // limits changed while a frame is half way through
  task automatic test_mid_frame_writes();
    write_limit(REG_MAX_SSID, RST_MAX_SSID);
    write_limit(REG_MAX_PW, RST_MAX_PW);
    send_frame('{CMD_NAME, 8'h61, 8'h62, 8'h63}, 1'b0);
    write_limit(REG_MAX_NAME, 8'd2);
    send_frame('{8'h64}, 1'b1);

    send_frame('{CMD_WIFI}, 1'b0);
    write_limit(REG_MAX_SSID, 8'd3);
    send_frame('{8'h04, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00}, 1'b1);

    send_frame('{CMD_WIFI, 8'h02, 8'h41, 8'h42}, 1'b0);
    write_limit(REG_MAX_PW, 8'd1);
    send_frame('{8'h01, 8'h50}, 1'b1);
  endtask

  // frames that reach and pass the byte counter saturation
  task automatic test_frame_overflow();
    byte_q_t fr;
    write_limit(REG_MAX_NAME, 8'd255);
    write_limit(REG_MAX_SSID, 8'd255);
    write_limit(REG_MAX_PW, 8'd255);
    gap_pct   = 5;
    stall_pct = 5;

    // longest good name fills the counter exactly
    fr = '{CMD_NAME};
    repeat (255) fr.push_back(rand_byte());
    send_frame(fr, 1'b1);

    // two bytes past the counter: offset saturates, verdict bad name
    fr = '{CMD_NAME};
    repeat (257) fr.push_back(rand_byte());
    send_frame(fr, 1'b1);

    // largest ssid and password, frame overflows inside the ssid
    fr = '{CMD_WIFI, 8'hff};
    repeat (255) fr.push_back(rand_byte());
    fr.push_back(8'hff);
    repeat (255) fr.push_back(rand_byte());
    send_frame(fr, 1'b1);

    // history is not affected by overflow
    fr = '{CMD_HISTORY};
    repeat (259) fr.push_back(rand_byte());
    send_frame(fr, 1'b1);
  endtask

  // random frames under changing limits and idling until the item count is reached
  task automatic test_random_frames();
    int unsigned next_setting;
    next_setting = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_setting) begin
        if ($urandom_range(0, 2) != 0) write_limit(REG_MAX_NAME, random_limit());
        if ($urandom_range(0, 2) != 0) write_limit(REG_MAX_SSID, random_limit());
        if ($urandom_range(0, 2) != 0) write_limit(REG_MAX_PW, random_limit());
        if ($urandom_range(0, 7) == 0) write_limit(REG_UNUSED, rand_byte());
        // the closing stretch runs with no idling at all
        if (ITEM_TARGET - items_sent <= 250) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 35;
          endcase
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            default: stall_pct = 35;
          endcase
        end
        next_setting = items_sent + 120;
      end
      send_random_frame();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_limit_extremes();
    test_mid_frame_writes();
    test_frame_overflow();
    test_random_frames();

    // drain, then wait for anything stray from the block
    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
